// ===== sv/sapq_pkg.sv =====
// sapq_pkg: shared types, codes and default sizes for the sorted array priority queue
// no dependencies
package sapq_pkg;

	localparam int unsigned DEPTH_DEF        = 64;
	localparam int unsigned KEY_BITS_DEF     = 16;
	localparam int unsigned PAYLOAD_BITS_DEF = 16;

	localparam int unsigned KEY_FIELD_W      = 16;
	localparam int unsigned PAYLOAD_FIELD_W  = 16;
	localparam int unsigned FILL_FIELD_W     = 7;
	localparam int unsigned STATUS_FIELD_W   = 2;

	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 40;

	typedef enum logic {
		FUNC_ENQ = 1'b0,
		FUNC_DEQ = 1'b1
	} func_t;

	typedef enum logic [STATUS_FIELD_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

// ===== sv/sapq_ctrl.sv =====
// sapq_ctrl: handshake controller, sequences load and execute of one word at a time
// depends on sapq_pkg
module sapq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output sapq_pkg::dp_cmd_t cmd
);

	sapq_pkg::state_t state_q, state_nxt;
	logic             valid_q;
	logic             exec;

	assign exec = (state_q == sapq_pkg::ST_EXEC) && (!valid_q || m_tready);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sapq_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = sapq_pkg::ST_EXEC;
				end
			end
			sapq_pkg::ST_EXEC: begin
				if (!valid_q || m_tready) begin
					state_nxt = sapq_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sapq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		case (state_q)
			sapq_pkg::ST_IDLE: s_tready = 1'b1;
			sapq_pkg::ST_EXEC: s_tready = 1'b0;
			default:           s_tready = 1'b0;
		endcase
		cmd.load = s_tready && s_tvalid;
		cmd.exec = exec;
		m_tvalid = valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sapq_pkg::ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (exec) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/sapq_dp.sv =====
// sapq_dp: row of compare-and-shift cells holding entries by descending key, plus result register
// depends on sapq_pkg
module sapq_dp #(
	parameter int unsigned DEPTH        = sapq_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS     = sapq_pkg::KEY_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = sapq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sapq_pkg::dp_cmd_t                     cmd,
	input  logic                                  func,
	input  logic [sapq_pkg::KEY_FIELD_W-1:0]      key,
	input  logic [sapq_pkg::PAYLOAD_FIELD_W-1:0]  payload,
	output logic [sapq_pkg::STATUS_FIELD_W-1:0]   status,
	output logic [sapq_pkg::KEY_FIELD_W-1:0]      out_key,
	output logic [sapq_pkg::PAYLOAD_FIELD_W-1:0]  out_payload,
	output logic [sapq_pkg::FILL_FIELD_W-1:0]     fill
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sapq_pkg::func_t         op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [KEY_BITS-1:0]     key_ext;
	logic [PAYLOAD_BITS-1:0] pay_ext;

	logic [KEY_BITS-1:0]     cell_key_q [DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_pay_q [DEPTH];
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	logic [DEPTH-1:0]        gt;

	logic                    full, empty, enq_ok, deq_ok;
	sapq_pkg::status_t       res_status;
	logic [KEY_BITS-1:0]     res_key;
	logic [PAYLOAD_BITS-1:0] res_pay;

	sapq_pkg::status_t       status_q;
	logic [KEY_BITS-1:0]     okey_q;
	logic [PAYLOAD_BITS-1:0] opay_q;
	logic [CNT_W-1:0]        fill_q;

	// field to storage width
	if (KEY_BITS <= sapq_pkg::KEY_FIELD_W) begin : g_kin_trunc
		assign key_ext = key[KEY_BITS-1:0];
	end else begin : g_kin_ext
		assign key_ext = {{(KEY_BITS - sapq_pkg::KEY_FIELD_W){1'b0}}, key};
	end
	if (PAYLOAD_BITS <= sapq_pkg::PAYLOAD_FIELD_W) begin : g_pin_trunc
		assign pay_ext = payload[PAYLOAD_BITS-1:0];
	end else begin : g_pin_ext
		assign pay_ext = {{(PAYLOAD_BITS - sapq_pkg::PAYLOAD_FIELD_W){1'b0}}, payload};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= sapq_pkg::func_t'(func);
			key_q <= key_ext;
			pay_q <= pay_ext;
		end
	end

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign enq_ok = (op_q == sapq_pkg::FUNC_ENQ) && !full;
	assign deq_ok = (op_q == sapq_pkg::FUNC_DEQ) && !empty;

	always_comb begin
		count_nxt  = count_q;
		res_status = sapq_pkg::STAT_OK;
		res_key    = '0;
		res_pay    = '0;
		if (op_q == sapq_pkg::FUNC_ENQ) begin
			if (full) begin
				res_status = sapq_pkg::STAT_FULL;
			end else begin
				count_nxt = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				res_status = sapq_pkg::STAT_EMPTY;
			end else begin
				count_nxt = count_q - CNT_W'(1);
				res_key   = cell_key_q[0];
				res_pay   = cell_pay_q[0];
			end
		end
	end

	// cell 0 holds the largest key, newest first among equals
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic                    lo_gt;
		logic [KEY_BITS-1:0]     lo_key, hi_key;
		logic [PAYLOAD_BITS-1:0] lo_pay, hi_pay;

		assign gt[gi] = (CNT_W'(gi) < count_q) && (cell_key_q[gi] > key_q);

		if (gi == 0) begin : g_bot
			assign lo_gt  = 1'b1;
			assign lo_key = key_q;
			assign lo_pay = pay_q;
		end else begin : g_mid
			assign lo_gt  = gt[gi-1];
			assign lo_key = cell_key_q[gi-1];
			assign lo_pay = cell_pay_q[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_top
			assign hi_key = cell_key_q[gi];
			assign hi_pay = cell_pay_q[gi];
		end else begin : g_below
			assign hi_key = cell_key_q[gi+1];
			assign hi_pay = cell_pay_q[gi+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (enq_ok && !gt[gi]) begin
					if (lo_gt) begin
						cell_key_q[gi] <= key_q;
						cell_pay_q[gi] <= pay_q;
					end else begin
						cell_key_q[gi] <= lo_key;
						cell_pay_q[gi] <= lo_pay;
					end
				end else if (deq_ok) begin
					cell_key_q[gi] <= hi_key;
					cell_pay_q[gi] <= hi_pay;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= res_status;
			okey_q   <= res_key;
			opay_q   <= res_pay;
			fill_q   <= count_nxt;
		end
	end

	assign status = status_q;

	if (KEY_BITS >= sapq_pkg::KEY_FIELD_W) begin : g_kout_trunc
		assign out_key = okey_q[sapq_pkg::KEY_FIELD_W-1:0];
	end else begin : g_kout_ext
		assign out_key = {{(sapq_pkg::KEY_FIELD_W - KEY_BITS){1'b0}}, okey_q};
	end
	if (PAYLOAD_BITS >= sapq_pkg::PAYLOAD_FIELD_W) begin : g_pout_trunc
		assign out_payload = opay_q[sapq_pkg::PAYLOAD_FIELD_W-1:0];
	end else begin : g_pout_ext
		assign out_payload = {{(sapq_pkg::PAYLOAD_FIELD_W - PAYLOAD_BITS){1'b0}}, opay_q};
	end
	if (CNT_W >= sapq_pkg::FILL_FIELD_W) begin : g_fill_trunc
		assign fill = fill_q[sapq_pkg::FILL_FIELD_W-1:0];
	end else begin : g_fill_ext
		assign fill = {{(sapq_pkg::FILL_FIELD_W - CNT_W){1'b0}}, fill_q};
	end

endmodule

// ===== sv/sorted_array_priority_queue_core.sv =====
// sorted_array_priority_queue_core: top level, controller plus compare-and-shift datapath
// the result word is registered by the execute step that follows the accepted input word
// no new input word is taken until that execute step is done, set by the load then execute sequence of the controller
// a waiting result does not block the next input word; only the execute step waits for it
// reset clears the entry count and handshake state; stored entries are left as they are
// depends on sapq_pkg, sapq_ctrl, sapq_dp
module sorted_array_priority_queue_core #(
	parameter int unsigned DEPTH        = sapq_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS     = sapq_pkg::KEY_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = sapq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sapq_pkg::S_TDATA_W-1:0]      s_tdata,  // key, payload
	input  logic                                s_tuser,  // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sapq_pkg::M_TDATA_W-1:0]      m_tdata,  // out_key, out_payload, fill, zero pad
	output logic [sapq_pkg::STATUS_FIELD_W-1:0] m_tuser   // status
);

	localparam int unsigned PAD_W = sapq_pkg::M_TDATA_W - sapq_pkg::KEY_FIELD_W
		- sapq_pkg::PAYLOAD_FIELD_W - sapq_pkg::FILL_FIELD_W;

	sapq_pkg::dp_cmd_t                     cmd;
	logic [sapq_pkg::KEY_FIELD_W-1:0]      out_key;
	logic [sapq_pkg::PAYLOAD_FIELD_W-1:0]  out_payload;
	logic [sapq_pkg::FILL_FIELD_W-1:0]     fill;

	sapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	sapq_dp #(
		.DEPTH        (DEPTH),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (s_tuser),
		.key         (s_tdata[sapq_pkg::KEY_FIELD_W-1:0]),
		.payload     (s_tdata[sapq_pkg::KEY_FIELD_W +: sapq_pkg::PAYLOAD_FIELD_W]),
		.status      (m_tuser),
		.out_key     (out_key),
		.out_payload (out_payload),
		.fill        (fill)
	);

	assign m_tdata = {{PAD_W{1'b0}}, fill, out_payload, out_key};

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an operation is in flight");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.exec))
		else $error("result raised without an execute step");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == sapq_pkg::STAT_EMPTY) |-> (m_tdata == '0))
		else $error("empty dequeue returned nonzero data or fill");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for sorted_array_priority_queue_core
// enqueue and dequeue words are checked against a behavioural queue model
// depends on sapq_pkg and sorted_array_priority_queue_core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QDEPTH     = sapq_pkg::DEPTH_DEF;
	localparam int unsigned KEY_W      = sapq_pkg::KEY_FIELD_W;
	localparam int unsigned PAY_W      = sapq_pkg::PAYLOAD_FIELD_W;
	localparam int unsigned FILL_W     = sapq_pkg::FILL_FIELD_W;
	localparam int unsigned STAT_W     = sapq_pkg::STATUS_FIELD_W;
	localparam int unsigned S_W        = sapq_pkg::S_TDATA_W;
	localparam int unsigned M_W        = sapq_pkg::M_TDATA_W;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned MAX_SHOWN  = 10;
	localparam int unsigned KEY_MAX    = (1 << KEY_W) - 1;

	typedef struct packed {
		sapq_pkg::status_t  status;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
		logic [FILL_W-1:0]  fill;
	} pq_result_t;

	typedef enum int unsigned {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_RUNS
	} ready_mode_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [S_W-1:0]    s_tdata  = '0;  // key, payload
	logic              s_tuser  = 1'b0;  // func
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [M_W-1:0]    m_tdata;  // out_key, out_payload, fill, zero pad
	logic [STAT_W-1:0] m_tuser;  // status

	logic [KEY_W-1:0]  pq_keys[$];
	logic [PAY_W-1:0]  pq_payloads[$];
	pq_result_t        due_results[$];

	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;

	sorted_array_priority_queue_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic pq_result_t pq_apply(sapq_pkg::func_t f, logic [KEY_W-1:0] k,
			logic [PAY_W-1:0] p);
		pq_result_t r;
		int pos;
		r.status  = sapq_pkg::STAT_OK;
		r.key     = '0;
		r.payload = '0;
		if (f == sapq_pkg::FUNC_ENQ) begin
			if (pq_keys.size() >= QDEPTH) begin
				r.status = sapq_pkg::STAT_FULL;
			end else begin
				// equal keys go above the older ones, so the newest leaves first
				pos = 0;
				while (pos < pq_keys.size() && pq_keys[pos] <= k)
					pos++;
				pq_keys.insert(pos, k);
				pq_payloads.insert(pos, p);
			end
		end else if (pq_keys.size() == 0) begin
			r.status = sapq_pkg::STAT_EMPTY;
		end else begin
			r.key     = pq_keys.pop_back();
			r.payload = pq_payloads.pop_back();
		end
		r.fill = FILL_W'(pq_keys.size());
		return r;
	endfunction

	task automatic send_word(sapq_pkg::func_t f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(9) == 0) ? 300 : $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {p, k};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		due_results.push_back(pq_apply(f, k, p));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
		burst_left = 0;
	endtask

	task automatic send_mixed(int unsigned count, int unsigned enq_pct, int unsigned key_max);
		repeat (count) begin
			if ($urandom_range(99) < enq_pct)
				send_word(sapq_pkg::FUNC_ENQ, KEY_W'($urandom_range(key_max)),
					PAY_W'($urandom_range(KEY_MAX)));
			else
				send_word(sapq_pkg::FUNC_DEQ, KEY_W'($urandom_range(KEY_MAX)),
					PAY_W'($urandom_range(KEY_MAX)));
		end
	endtask

	task automatic test_empty_dequeue();
		send_word(sapq_pkg::FUNC_DEQ, 16'h0000, 16'h0000);
		send_word(sapq_pkg::FUNC_DEQ, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_key_extremes();
		send_word(sapq_pkg::FUNC_ENQ, 16'h0000, 16'hFFFF);
		send_word(sapq_pkg::FUNC_ENQ, 16'hFFFF, 16'h0000);
		send_word(sapq_pkg::FUNC_ENQ, 16'h5555, 16'hAAAA);
		send_word(sapq_pkg::FUNC_ENQ, 16'hAAAA, 16'h5555);
		repeat (5) send_word(sapq_pkg::FUNC_DEQ, 16'hA5A5, 16'h5A5A);
	endtask

	task automatic test_equal_keys();
		send_word(sapq_pkg::FUNC_ENQ, 16'h1234, 16'h0001);
		send_word(sapq_pkg::FUNC_ENQ, 16'h1234, 16'h0002);
		send_word(sapq_pkg::FUNC_ENQ, 16'h1233, 16'h0003);
		send_word(sapq_pkg::FUNC_ENQ, 16'h1234, 16'h0004);
		repeat (5) send_word(sapq_pkg::FUNC_DEQ, 16'h0000, 16'h0000);
	endtask

	task automatic test_fill_to_capacity();
		send_mixed(500, 80, KEY_MAX);
	endtask

	task automatic test_random_mix();
		send_mixed(300, 50, KEY_MAX);
		wait_results_drained();
		send_mixed(300, 50, KEY_MAX);
	endtask

	task automatic test_tied_keys();
		send_mixed(450, 55, 3);
	endtask

	task automatic test_drain_to_empty();
		send_mixed(400, 25, KEY_MAX);
	endtask

	// receiver ready pattern, switching at random among always-ready, random and run-length modes
	ready_mode_t ready_mode = RDY_ALWAYS;
	int unsigned mode_left = 0;
	int unsigned run_left = 0;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(2));
			mode_left  = $urandom_range(32, 256);
		end
		mode_left--;
		case (ready_mode)
			RDY_ALWAYS: begin
				m_tready <= 1'b1;
			end
			RDY_RANDOM: begin
				m_tready <= ($urandom_range(3) != 0);
			end
			default: begin
				if (run_left == 0) begin
					m_tready <= !m_tready;
					run_left = m_tready ? $urandom_range(1, 24) : $urandom_range(1, 8);
				end else begin
					run_left--;
				end
			end
		endcase
	end

	always @(posedge clk) begin : check_result
		pq_result_t got;
		pq_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status  = sapq_pkg::status_t'(m_tuser);
			got.key     = m_tdata[KEY_W-1:0];
			got.payload = m_tdata[KEY_W +: PAY_W];
			got.fill    = m_tdata[KEY_W + PAY_W +: FILL_W];
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result word: status %0d key %h payload %h fill %0d",
						got.status, got.key, got.payload, got.fill);
			end else begin
				want = due_results.pop_front();
				if (got.status !== want.status || got.key !== want.key ||
						got.payload !== want.payload || got.fill !== want.fill) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display({"result word differs: expected status %0d key %h ",
							"payload %h fill %0d, got status %0d key %h payload %h ",
							"fill %0d"},
							want.status, want.key, want.payload, want.fill,
							got.status, got.key, got.payload, got.fill);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_dequeue();
		test_key_extremes();
		test_equal_keys();
		wait_results_drained();
		test_fill_to_capacity();
		wait_results_drained();
		test_random_mix();
		test_tied_keys();
		wait_results_drained();
		test_drain_to_empty();

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
